/* rtl/sud_pkg.sv */
// shared types and constants of the sms user-data decoder
package sud_pkg;

  localparam int BYTE_W      = 8;
  localparam int COUNT_W     = 8;
  localparam int DONE_W      = 9;
  localparam int STORE_W     = 14;
  localparam int HELD_W      = 4;
  localparam int SEPTET_BITS = 7;
  localparam int RQ_DEPTH    = 4;
  localparam int RQ_AW       = 2;
  localparam int RQ_CW       = 3;

  localparam logic [15:0] BOM_NORMAL  = 16'hFEFF;
  localparam logic [15:0] BOM_SWAPPED = 16'hFFFE;

  // configuration register indexes
  localparam logic REG_DECODE_MODE = 1'b0;
  localparam logic REG_CHAR_COUNT  = 1'b1;

  typedef enum logic [1:0] {
    MODE_OCTET   = 2'd0,
    MODE_SEPTET  = 2'd1,
    MODE_UNICODE = 2'd2,
    MODE_BAD     = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    ORD_UNCHECKED = 2'd0,
    ORD_NORMAL    = 2'd1,
    ORD_SWAPPED   = 2'd2,
    ORD_NONE      = 2'd3
  } order_t;

  typedef struct packed {
    logic [BYTE_W-1:0] out_byte;
    logic              run_end;
    logic              msg_end;
    logic              bad_request;
  } res_t;

endpackage

/* rtl/sud_in_if.sv */
// input byte channel
interface sud_in_if;
  import sud_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] in_byte;
  logic              in_last;

  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

/* rtl/sud_out_if.sv */
// decoded result channel
interface sud_out_if;
  import sud_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              run_end;
  logic              msg_end;
  logic              bad_request;

  modport source (output valid, output out_byte, output run_end, output msg_end,
                  output bad_request, input ready);
  modport sink   (input valid, input out_byte, input run_end, input msg_end,
                  input bad_request, output ready);
endinterface

/* rtl/sud_cfg_if.sv */
// configuration write channel
interface sud_cfg_if;
  import sud_pkg::*;

  logic               valid;
  logic               ready;
  logic               cfg_index;
  logic [COUNT_W-1:0] cfg_data;

  modport source (output valid, output cfg_index, output cfg_data, input ready);
  modport sink   (input valid, input cfg_index, input cfg_data, output ready);
endinterface

/* rtl/sud_core.sv */
// decode logic and message state: one byte in, up to two results out
module sud_core #(
  parameter int MAX_CHARS = 255
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         fire,
  input  logic [sud_pkg::BYTE_W-1:0]   item_byte,
  input  logic                         item_last,
  input  sud_pkg::mode_t               mode,
  input  logic [sud_pkg::COUNT_W-1:0]  char_count,
  output logic [1:0]                   res_n,
  output sud_pkg::res_t                res0,
  output sud_pkg::res_t                res1
);
  import sud_pkg::*;

  logic [STORE_W-1:0] store_r, store_nxt;
  logic [HELD_W-1:0]  bits_r, bits_nxt;
  logic [DONE_W-1:0]  done_r, done_nxt;
  logic [BYTE_W-1:0]  held_r, held_nxt;
  logic               phase_r, phase_nxt;
  order_t             order_r, order_nxt;

  logic               bad;
  logic [DONE_W-1:0]  limit, done_p1, done_p2;
  logic [1:0]         cand_n;
  logic [BYTE_W-1:0]  cand0, cand1;
  logic               emit0, emit1;

  // septet unpack, two steps
  logic [STORE_W-1:0] st1, st2, st3;
  logic [HELD_W-1:0]  b1, sh1, sh2;
  logic [6:0]         c1, c2;
  logic               sep_go, sep_two;
  logic [15:0]        pair_code;

  assign done_p1 = done_r + DONE_W'(1);
  assign done_p2 = done_r + DONE_W'(2);

  // unicode counts bytes, two per character
  assign limit = (mode == MODE_UNICODE) ? {char_count, 1'b0} : {1'b0, char_count};

  assign st1    = {store_r[5:0], item_byte};
  assign b1     = bits_r + HELD_W'(8);
  assign sh1    = b1 - HELD_W'(SEPTET_BITS);
  assign c1     = 7'(st1 >> sh1);
  assign st2    = st1 & ((STORE_W'(1) << sh1) - STORE_W'(1));
  assign sh2    = sh1 - HELD_W'(SEPTET_BITS);
  assign c2     = 7'(st2 >> sh2);
  assign st3    = st2 & ((STORE_W'(1) << sh2) - STORE_W'(1));
  assign sep_go = (done_r < limit) && (bits_r < HELD_W'(2 * SEPTET_BITS - 7));
  assign sep_two = (sh1 >= HELD_W'(SEPTET_BITS)) && (done_p1 < limit);

  assign pair_code = {held_r, item_byte};
  assign bad = (mode == MODE_BAD) || (char_count > COUNT_W'(MAX_CHARS));

  always_comb begin
    store_nxt = store_r;
    bits_nxt  = bits_r;
    held_nxt  = held_r;
    phase_nxt = phase_r;
    order_nxt = order_r;
    cand_n    = 2'd0;
    cand0     = item_byte;
    cand1     = item_byte;

    if (!bad) begin
      unique case (mode)
        MODE_OCTET: begin
          cand_n = 2'd1;
        end
        MODE_SEPTET: begin
          if (sep_go) begin
            cand_n    = sep_two ? 2'd2 : 2'd1;
            cand0     = {1'b0, c1};
            cand1     = {1'b0, c2};
            store_nxt = sep_two ? st3 : st2;
            bits_nxt  = sep_two ? sh2 : sh1;
          end
        end
        MODE_UNICODE: begin
          if (!phase_r) begin
            held_nxt  = item_byte;
            phase_nxt = 1'b1;
            if (item_last && order_r != ORD_SWAPPED) begin
              cand_n = 2'd1;
            end
          end else begin
            phase_nxt = 1'b0;
            if (order_r == ORD_UNCHECKED) begin
              if (pair_code == BOM_NORMAL) begin
                order_nxt = ORD_NORMAL;
              end else if (pair_code == BOM_SWAPPED) begin
                order_nxt = ORD_SWAPPED;
              end else begin
                order_nxt = ORD_NONE;
                cand_n    = 2'd2;
                cand0     = held_r;
              end
            end else if (order_r == ORD_SWAPPED) begin
              cand_n = 2'd2;
              cand1  = held_r;
            end else begin
              cand_n = 2'd2;
              cand0  = held_r;
            end
          end
        end
        default: begin
        end
      endcase
    end

    emit0 = (cand_n != 2'd0) && (done_r < limit);
    emit1 = (cand_n == 2'd2) && (done_p1 < limit);

    if (bad) begin
      res_n = 2'd1;
      res0  = '{out_byte: '0, run_end: 1'b1, msg_end: item_last, bad_request: 1'b1};
      res1  = '{out_byte: '0, run_end: 1'b1, msg_end: item_last, bad_request: 1'b1};
      done_nxt = done_r;
    end else begin
      res_n = {1'b0, emit0} + {1'b0, emit1};
      res0  = '{out_byte: cand0, run_end: !emit1,
                msg_end: (done_p1 == limit) || (item_last && !emit1), bad_request: 1'b0};
      res1  = '{out_byte: cand1, run_end: 1'b1,
                msg_end: (done_p2 == limit) || item_last, bad_request: 1'b0};
      done_nxt = done_r + DONE_W'(res_n);
    end

    // end of message clears everything but the registers
    if (item_last) begin
      store_nxt = '0;
      bits_nxt  = '0;
      done_nxt  = '0;
      held_nxt  = '0;
      phase_nxt = 1'b0;
      order_nxt = ORD_UNCHECKED;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      store_r <= '0;
      bits_r  <= '0;
      done_r  <= '0;
      held_r  <= '0;
      phase_r <= 1'b0;
      order_r <= ORD_UNCHECKED;
    end else if (fire) begin
      store_r <= store_nxt;
      bits_r  <= bits_nxt;
      done_r  <= done_nxt;
      held_r  <= held_nxt;
      phase_r <= phase_nxt;
      order_r <= order_nxt;
    end
  end

endmodule

/* rtl/sud_rq.sv */
// result queue: takes up to two results a cycle, hands out one
module sud_rq (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       push_n,
  input  sud_pkg::res_t    push0,
  input  sud_pkg::res_t    push1,
  output logic             room,
  sud_out_if.source        out_ch
);
  import sud_pkg::*;

  res_t             mem_r [RQ_DEPTH];
  logic [RQ_AW-1:0] wr_r, wr_nxt;
  logic [RQ_AW-1:0] rd_r, rd_nxt;
  logic [RQ_CW-1:0] cnt_r, cnt_nxt;
  logic             pop;
  logic [RQ_AW-1:0] wr_p1;

  assign room  = cnt_r <= RQ_CW'(RQ_DEPTH - 2);
  assign pop   = out_ch.valid && out_ch.ready;
  assign wr_p1 = wr_r + RQ_AW'(1);

  assign out_ch.valid       = cnt_r != '0;
  assign out_ch.out_byte    = mem_r[rd_r].out_byte;
  assign out_ch.run_end     = mem_r[rd_r].run_end;
  assign out_ch.msg_end     = mem_r[rd_r].msg_end;
  assign out_ch.bad_request = mem_r[rd_r].bad_request;

  always_comb begin
    wr_nxt  = wr_r + RQ_AW'(push_n);
    rd_nxt  = rd_r + RQ_AW'(pop);
    cnt_nxt = cnt_r + RQ_CW'(push_n) - RQ_CW'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_n != 2'd0) begin
      mem_r[wr_r] <= push0;
    end
    if (push_n == 2'd2) begin
      mem_r[wr_p1] <= push1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

/* rtl/sms_user_data_decoder.sv */
// top level of the sms user-data decoder
//
// usage
//   in_ch carries one raw user-data byte per word, with in_last on the final
//   byte of the field. out_ch carries the decoded words: a byte, a septet in
//   the low seven bits, or an error word with bad_request set and byte zero.
//   cfg_ch writes decode_mode (index 0) and char_count (index 1); it is
//   always ready and should be written only while no byte is in flight.
// timing
//   an accepted byte is held in the input register until the result queue has
//   room for two results, is then decoded and pushed into the queue, and its
//   first result is valid on out_ch straight from the queue. a byte yields
//   zero, one or two results; the single result port sets the pace: one byte
//   per cycle while out_ch stays ready and bytes give one result each, fewer
//   bytes when bytes give two.
// reset
//   rst_n low clears the registers to octet mode with a zero count, the
//   message state and the result queue.
// stall
//   when out_ch is held off the four-entry queue backs up, decode pauses once
//   three words wait, and in_ready falls once the input register is also
//   occupied; nothing is lost
module sms_user_data_decoder #(
  parameter int MAX_CHARS = 255
) (
  input  logic       clk,
  input  logic       rst_n,
  sud_in_if.sink     in_ch,
  sud_out_if.source  out_ch,
  sud_cfg_if.sink    cfg_ch
);
  import sud_pkg::*;

  // configuration registers
  mode_t              mode_r;
  logic [COUNT_W-1:0] count_r;

  // input register
  logic              in_vld_r;
  logic [BYTE_W-1:0] in_byte_r;
  logic              in_last_r;

  logic       room;
  logic       fire;
  logic       in_take;
  logic [1:0] res_n;
  res_t       res0, res1;

  // decode the held byte when the queue can absorb two results
  assign fire        = in_vld_r && room;
  assign in_ch.ready = !in_vld_r || room;
  assign in_take     = in_ch.valid && in_ch.ready;
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_OCTET;
      count_r <= '0;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.cfg_index)
        REG_DECODE_MODE: mode_r  <= mode_t'(cfg_ch.cfg_data[1:0]);
        REG_CHAR_COUNT:  count_r <= cfg_ch.cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (fire) begin
      in_vld_r <= 1'b0;
    end
  end

  // payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_byte_r <= in_ch.in_byte;
      in_last_r <= in_ch.in_last;
    end
  end

  sud_core #(
    .MAX_CHARS (MAX_CHARS)
  ) u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .fire       (fire),
    .item_byte  (in_byte_r),
    .item_last  (in_last_r),
    .mode       (mode_r),
    .char_count (count_r),
    .res_n      (res_n),
    .res0       (res0),
    .res1       (res1)
  );

  // only committed decodes push results
  sud_rq u_rq (
    .clk    (clk),
    .rst_n  (rst_n),
    .push_n (fire ? res_n : 2'd0),
    .push0  (res0),
    .push1  (res1),
    .room   (room),
    .out_ch (out_ch)
  );

endmodule

/* test/sms_user_data_decoder_checker.sv */
// checker for the sms user-data decoder: predicts decoded words and compares them
`timescale 1ns / 1ps

module sms_user_data_decoder_checker #(
  parameter int MAX_CHARS = 255
) (
  input  logic clk,
  input  logic rst_n,
  sud_in_if    in_mon,
  sud_out_if   out_mon,
  sud_cfg_if   cfg_mon,
  output int   fail_count,
  output int   owed
);
  import sud_pkg::*;

  // register copies
  mode_t              mode_reg;
  logic [COUNT_W-1:0] count_reg;

  // message state
  logic [STORE_W-1:0] septet_bits;
  logic [HELD_W-1:0]  septet_cnt;
  logic [DONE_W-1:0]  chars_out;
  logic [BYTE_W-1:0]  first_half;
  logic               pair_open;
  order_t             byte_order;

  res_t decoded_q[$];
  res_t step_res[2];
  int   step_n;
  int   errors;
  int   words_seen;

  task automatic clear_msg();
    septet_bits = '0;
    septet_cnt  = '0;
    chars_out   = '0;
    first_half  = '0;
    pair_open   = 1'b0;
    byte_order  = ORD_UNCHECKED;
  endtask

  // at most two characters per input word, none past the limit
  task automatic put_char(input logic [BYTE_W-1:0] c, input logic [DONE_W-1:0] lim);
    if (step_n < 2 && chars_out < lim) begin
      step_res[step_n].out_byte    = c;
      step_res[step_n].run_end     = 1'b0;
      step_res[step_n].msg_end     = (chars_out + 9'd1 == lim);
      step_res[step_n].bad_request = 1'b0;
      chars_out = chars_out + 9'd1;
      step_n++;
    end
  endtask

  task automatic decode_word(input logic [BYTE_W-1:0] b, input logic last);
    logic [DONE_W-1:0]  lim;
    logic [HELD_W-1:0]  sh;
    logic [STORE_W-1:0] shifted;
    res_t               err;
    step_n = 0;
    if (mode_reg == MODE_BAD || int'(count_reg) > MAX_CHARS) begin
      err.out_byte    = '0;
      err.run_end     = 1'b1;
      err.msg_end     = last;
      err.bad_request = 1'b1;
      decoded_q.push_back(err);
      if (last) clear_msg();
      return;
    end
    case (mode_reg)
      MODE_OCTET: begin
        put_char(b, {1'b0, count_reg});
      end
      MODE_SEPTET: begin
        lim = {1'b0, count_reg};
        if (chars_out < lim && septet_cnt < 2 * SEPTET_BITS - 7) begin
          septet_bits = {septet_bits[STORE_W-9:0], b};
          septet_cnt  = septet_cnt + 4'd8;
          while (septet_cnt >= SEPTET_BITS && step_n < 2 && chars_out < lim) begin
            sh      = septet_cnt - 4'd7;
            shifted = septet_bits >> sh;
            put_char({1'b0, shifted[6:0]}, lim);
            septet_cnt  = sh;
            septet_bits = septet_bits & ((14'd1 << sh) - 14'd1);
          end
        end
      end
      default: begin
        lim = {count_reg, 1'b0};
        if (!pair_open) begin
          first_half = b;
          pair_open  = 1'b1;
          // odd tail kept unless the pairs are being swapped
          if (last && byte_order != ORD_SWAPPED) put_char(b, lim);
        end else begin
          pair_open = 1'b0;
          case (byte_order)
            ORD_UNCHECKED: begin
              if ({first_half, b} == BOM_NORMAL) begin
                byte_order = ORD_NORMAL;
              end else if ({first_half, b} == BOM_SWAPPED) begin
                byte_order = ORD_SWAPPED;
              end else begin
                byte_order = ORD_NONE;
                put_char(first_half, lim);
                put_char(b, lim);
              end
            end
            ORD_SWAPPED: begin
              put_char(b, lim);
              put_char(first_half, lim);
            end
            default: begin
              put_char(first_half, lim);
              put_char(b, lim);
            end
          endcase
        end
      end
    endcase
    if (step_n > 0) begin
      step_res[step_n-1].run_end = 1'b1;
      if (last) step_res[step_n-1].msg_end = 1'b1;
    end
    for (int i = 0; i < step_n; i++) decoded_q.push_back(step_res[i]);
    if (last) clear_msg();
  endtask

  always @(posedge clk) begin
    res_t got;
    res_t want;
    if (!rst_n) begin
      mode_reg  = MODE_OCTET;
      count_reg = '0;
      clear_msg();
      decoded_q.delete();
      errors     = 0;
      words_seen = 0;
    end else begin
      // results first, so a word cannot be matched against its own cause
      if (out_mon.valid && out_mon.ready) begin
        got.out_byte    = out_mon.out_byte;
        got.run_end     = out_mon.run_end;
        got.msg_end     = out_mon.msg_end;
        got.bad_request = out_mon.bad_request;
        if (decoded_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("%0t: word %0d unexpected: byte %02h run_end %b msg_end %b bad %b",
                     $realtime, words_seen, got.out_byte, got.run_end, got.msg_end,
                     got.bad_request);
        end else begin
          want = decoded_q.pop_front();
          if (got.out_byte !== want.out_byte || got.run_end !== want.run_end ||
              got.msg_end !== want.msg_end || got.bad_request !== want.bad_request) begin
            errors++;
            if (errors <= 10)
              $display("%0t: word %0d expected byte %02h run_end %b msg_end %b bad %b, %s",
                       $realtime, words_seen, want.out_byte, want.run_end, want.msg_end,
                       want.bad_request,
                       $sformatf("got byte %02h run_end %b msg_end %b bad %b",
                                 got.out_byte, got.run_end, got.msg_end, got.bad_request));
          end
        end
        words_seen++;
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        if (cfg_mon.cfg_index == REG_DECODE_MODE) mode_reg = mode_t'(cfg_mon.cfg_data[1:0]);
        else count_reg = cfg_mon.cfg_data;
      end
      if (in_mon.valid && in_mon.ready) decode_word(in_mon.in_byte, in_mon.in_last);
    end
    fail_count <= errors;
    owed       <= decoded_q.size();
  end

endmodule

/* test/sms_user_data_decoder_tb.sv */
// top of the sms user-data decoder testbench: stimulus, back-pressure and verdict
`timescale 1ns / 1ps

module sms_user_data_decoder_tb;
  import sud_pkg::*;

  logic clk;
  logic rst_n;

  sud_in_if  in_ch();
  sud_out_if out_ch();
  sud_cfg_if cfg_ch();

  int fails;
  int owed;

  sms_user_data_decoder #(.MAX_CHARS(255)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  // the checker sits beside the block and only watches
  sms_user_data_decoder_checker #(.MAX_CHARS(255)) decode_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_mon     (in_ch),
    .out_mon    (out_ch),
    .cfg_mon    (cfg_ch),
    .fail_count (fails),
    .owed       (owed)
  );

  // 10 ns clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  logic [BYTE_W-1:0] msg_q[$];   // bytes of the message about to go out
  logic              sender_calm; // no gaps at all for the current message
  int                sent;

  // gaps: mostly none, some short, a few long
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // byte values lean toward the extremes now and then
  function automatic logic [BYTE_W-1:0] pick_byte();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'h00;
    if (r < 20) return 8'hFF;
    return BYTE_W'($urandom_range(0, 255));
  endfunction

  // valid stays high from word to word unless a gap is wanted
  task automatic send_byte(input logic [BYTE_W-1:0] b, input logic last);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    sent++;
  endtask

  task automatic send_msg();
    sender_calm = ($urandom_range(0, 3) == 0);
    foreach (msg_q[i]) send_byte(msg_q[i], i == msg_q.size() - 1);
  endtask

  // hold off until every predicted word is out, then let the pipeline drain
  task automatic wait_idle();
    int spent;
    in_ch.valid <= 1'b0;
    // owed is a registered copy in the checker, so it lags the acceptance edge
    repeat (2) @(posedge clk);
    spent = 0;
    while (owed != 0 && spent < 100000) begin
      @(posedge clk);
      spent++;
    end
    repeat (8) @(posedge clk);
  endtask

  // both registers back to back, valid held high across the pair
  task automatic write_config(input mode_t m, input logic [COUNT_W-1:0] c);
    cfg_ch.valid     <= 1'b1;
    cfg_ch.cfg_index <= REG_DECODE_MODE;
    cfg_ch.cfg_data  <= {6'b0, m};
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.cfg_index <= REG_CHAR_COUNT;
    cfg_ch.cfg_data  <= c;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  // result side: random stalls, with calm stretches of steady ready
  initial begin : result_drain
    int calm_left;
    int stall_left;
    int pick;
    calm_left  = 0;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (calm_left > 0) begin
        calm_left--;
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 3) calm_left = $urandom_range(20, 200);
        else if (pick < 25) stall_left = $urandom_range(1, 3);
        else if (pick < 28) stall_left = $urandom_range(8, 40);
      end
    end
  end

  initial begin : stimulus
    mode_t m;
    int    count;
    int    need;
    int    len;
    int    msgs;
    int    phase;
    int    base;
    int    r;
    logic  big;

    sent        = 0;
    sender_calm = 1'b0;
    rst_n            <= 1'b0;
    in_ch.valid      <= 1'b0;
    in_ch.in_byte    <= '0;
    in_ch.in_last    <= 1'b0;
    cfg_ch.valid     <= 1'b0;
    cfg_ch.cfg_index <= REG_DECODE_MODE;
    cfg_ch.cfg_data  <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // ---------------- directed words ----------------

    // reset config is octet with a zero count: nothing comes out
    msg_q = {8'h00};
    send_msg();

    // unsupported mode: one error word per byte, msg_end follows in_last
    wait_idle();
    write_config(MODE_BAD, 8'd0);
    msg_q = {8'hFF, 8'h00};
    send_msg();

    // count reached on the first byte, then the count is raised mid-message;
    // the new limit applies from the next byte and the count of characters done is kept
    wait_idle();
    write_config(MODE_OCTET, 8'd1);
    sender_calm = 1'b0;
    send_byte(8'h80, 1'b0);
    wait_idle();
    write_config(MODE_OCTET, 8'd255);
    send_byte(8'h7F, 1'b1);

    // count reached before in_last: the last byte gives nothing and flags nothing
    wait_idle();
    write_config(MODE_OCTET, 8'd2);
    msg_q = {8'h5A, 8'hA5, 8'h3C};
    send_msg();

    // septets: the seventh byte completes two characters at once
    wait_idle();
    write_config(MODE_SEPTET, 8'd8);
    msg_q = {8'hFF, 8'h00, 8'h80, 8'h7F, 8'hAA, 8'h55, 8'h01};
    send_msg();

    // normal byte-order mark dropped, odd tail byte kept
    wait_idle();
    write_config(MODE_UNICODE, 8'd255);
    msg_q = {8'hFE, 8'hFF, 8'h01};
    send_msg();

    // reversed mark: pairs swapped, count reached, odd tail dropped
    wait_idle();
    write_config(MODE_UNICODE, 8'd2);
    msg_q = {8'hFF, 8'hFE, 8'h12, 8'h34, 8'h56, 8'h78, 8'h9A};
    send_msg();

    // ---------------- random phases ----------------
    // first two phases run to large counts, the rest mostly stay small
    base  = sent;
    phase = 0;
    while (sent - base < 1100) begin
      big = 1'b0;
      if (phase == 0) begin
        m     = MODE_SEPTET;
        count = 255;
        big   = 1'b1;
      end else if (phase == 1) begin
        m     = MODE_UNICODE;
        count = $urandom_range(128, 140);
        big   = 1'b1;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 25) m = MODE_OCTET;
        else if (r < 55) m = MODE_SEPTET;
        else if (r < 92) m = MODE_UNICODE;
        else m = MODE_BAD;
        r = $urandom_range(0, 99);
        if (r < 8) count = 0;
        else if (r < 12) count = 255;
        else if (r < 16) count = $urandom_range(100, 254);
        else count = $urandom_range(1, 12);
      end

      // every phase starts from an idle block
      wait_idle();
      write_config(m, COUNT_W'(count));

      msgs = big ? 1 : $urandom_range(1, 4);
      repeat (msgs) begin
        // len near the need so limit is hit or just missed; 1..40 if !big and need>40
        case (m)
          MODE_OCTET:   need = count;
          MODE_SEPTET:  need = (7 * count + 7) / 8;
          MODE_UNICODE: need = 2 * count + 2;
          default:      need = 3;
        endcase
        if (!big && need > 40) len = $urandom_range(1, 40);
        else len = need + $urandom_range(0, 6) - 3;
        if (len < 1) len = 1;
        msg_q.delete();
        if (m == MODE_UNICODE) begin
          r = $urandom_range(0, 99);
          if (r < 40) begin
            msg_q.push_back(8'hFE);
            msg_q.push_back(8'hFF);
          end else if (r < 75) begin
            msg_q.push_back(8'hFF);
            msg_q.push_back(8'hFE);
          end
        end
        while (msg_q.size() < len) msg_q.push_back(pick_byte());
        send_msg();
      end
      phase++;
    end

    // ---------------- drain and verdict ----------------
    wait_idle();
    if (fails == 0 && owed == 0) begin
      $display("sms_user_data_decoder_tb OK");
    end else begin
      if (owed != 0) $display("%0d predicted words never came out", owed);
      $display("sms_user_data_decoder_tb NOT OK");
    end
    $finish;
  end

  // hard stop, far beyond the slowest passing run
  initial begin : watchdog
    #10_000_000;
    $display("timeout with %0d words still owed", owed);
    $display("sms_user_data_decoder_tb NOT OK");
    $finish;
  end

endmodule
